@@ src/dense_graph_shortest_path_macros.svh @@
// Assertion shorthands used by the top-level RTL file.
`ifndef DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DGSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dgsp assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define DGSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dgsp assertion failed");

`endif

@@ src/dgsp_pkg.sv @@
package dgsp_pkg;

	localparam int NODE_COUNT     = 32;
	localparam int NODE_BITS      = $clog2(NODE_COUNT);
	localparam int WEIGHT_BITS    = 16;
	localparam int DIST_BITS      = 21;
	localparam int EDGE_DEPTH     = NODE_COUNT * NODE_COUNT;
	localparam int EDGE_ADDR_BITS = $clog2(EDGE_DEPTH);
	localparam int ENTRY_BITS     = DIST_BITS + NODE_BITS;
	localparam int MAX_ITEMS      = 32;

	localparam logic CMD_SET   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [NODE_BITS-1:0]      node_t;
	typedef logic [DIST_BITS-1:0]      dist_t;
	typedef logic [WEIGHT_BITS-1:0]    weight_t;
	typedef logic [EDGE_ADDR_BITS-1:0] eaddr_t;

	// Control for one relaxation step, lined up with the memory read data
	typedef struct packed {
		logic valid;
		logic clear;
		logic visited;
		logic reached;
	} relax_ctl_t;

	// Running minimum over unvisited reached nodes
	typedef struct packed {
		logic  found;
		node_t node;
		dist_t cost;
	} best_t;

endpackage

@@ src/dgsp_ram.sv @@
module dgsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/dgsp_relax.sv @@
module dgsp_relax (
	input  logic                clk,
	input  logic                arst_n,
	input  dgsp_pkg::relax_ctl_t ctl,
	input  dgsp_pkg::node_t     v,
	input  dgsp_pkg::dist_t     du,
	input  dgsp_pkg::weight_t   w,
	input  dgsp_pkg::dist_t     d,
	output logic                upd,
	output dgsp_pkg::dist_t     nd,
	output dgsp_pkg::best_t     best
);

	logic [dgsp_pkg::DIST_BITS:0] sum;
	logic                          cand;
	dgsp_pkg::dist_t               deff;
	dgsp_pkg::best_t               best_q;

	// Candidate distance through the current node
	assign sum = {1'b0, du} + (dgsp_pkg::DIST_BITS + 1)'(w);
	assign nd  = sum[dgsp_pkg::DIST_BITS-1:0];

	// Take the edge on a strictly shorter distance or a first reach
	assign upd = ctl.valid && !ctl.visited && (w != '0) && (!ctl.reached || (nd < d));

	// Distance of the neighbor after this step
	assign cand = ctl.valid && !ctl.visited && (ctl.reached || upd);
	assign deff = upd ? nd : d;

	// Track the lowest-index node of smallest distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q.found <= 1'b0;
			best_q.node  <= '0;
			best_q.cost  <= '0;
		end else if (ctl.clear) begin
			best_q.found <= 1'b0;
		end else if (cand && (!best_q.found || (deff < best_q.cost))) begin
			best_q.found <= 1'b1;
			best_q.node  <= v;
			best_q.cost  <= deff;
		end
	end

	assign best = best_q;

endmodule

@@ src/dense_graph_shortest_path.sv @@
// Channel   Ports                                           Handshake
// command   command, first_node, second_node, weight        start & !busy
// result    path_node, path_distance, unreachable, last     result_strobe, one cycle
//
// A set-edge item writes both directions of the weight memory, in S_IDLE then S_EDGE2.
// A query settles up to 31 nodes, each in a pass of S_RELAX, S_DRAIN and S_DECIDE
// with one weight memory read per neighbor, then emits each path item through
// S_WALK_RD and S_WALK_EM. After reset all 1024 weight entries are cleared, busy high.
// Results cannot be stalled; each item shows for one cycle.
`include "dense_graph_shortest_path_macros.svh"

module dense_graph_shortest_path (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    command,
	input  dgsp_pkg::node_t         first_node,
	input  dgsp_pkg::node_t         second_node,
	input  dgsp_pkg::weight_t       weight,
	output logic                    result_strobe,
	output dgsp_pkg::node_t         path_node,
	output dgsp_pkg::dist_t         path_distance,
	output logic                    unreachable,
	output logic                    last
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EDGE2, S_INIT, S_RELAX, S_DRAIN, S_DECIDE,
		S_CHECK, S_WALK_RD, S_WALK_EM
	} state_t;

	state_t                       state_q;
	dgsp_pkg::eaddr_t             clr_q;
	dgsp_pkg::node_t              a_q, b_q;
	dgsp_pkg::weight_t            w_q;
	dgsp_pkg::node_t              src_q, goal_q;
	dgsp_pkg::node_t              u_q, v_q, node_q, picks_q, k_q;
	dgsp_pkg::dist_t              du_q;
	logic [dgsp_pkg::NODE_COUNT-1:0] visited_q, reached_q;
	logic                         valid_s1;
	dgsp_pkg::node_t              v_s1;

	logic                         strobe_q, unr_q, last_q;
	dgsp_pkg::node_t              pnode_q;
	dgsp_pkg::dist_t              pdist_q;

	logic                         e_we;
	dgsp_pkg::eaddr_t             e_waddr, e_raddr;
	dgsp_pkg::weight_t            e_wdata, e_rdata;
	logic                         n_we;
	dgsp_pkg::node_t              n_waddr, n_raddr;
	logic [dgsp_pkg::ENTRY_BITS-1:0] n_wdata, n_rdata;
	dgsp_pkg::dist_t              n_rdist;
	dgsp_pkg::node_t              n_rpar;

	dgsp_pkg::relax_ctl_t         rctl;
	logic                         upd;
	dgsp_pkg::dist_t              nd;
	dgsp_pkg::best_t              best;
	logic                         fin;

	assign n_rdist = n_rdata[dgsp_pkg::ENTRY_BITS-1:dgsp_pkg::NODE_BITS];
	assign n_rpar  = n_rdata[dgsp_pkg::NODE_BITS-1:0];

	// Weight memory port selection: clear sweep, two-way edge write, row read
	always_comb begin
		e_we    = 1'b0;
		e_waddr = clr_q;
		e_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				e_we = 1'b1;
			end
			S_IDLE: begin
				e_we    = start && (command == dgsp_pkg::CMD_SET);
				e_waddr = {first_node, second_node};
				e_wdata = weight;
			end
			S_EDGE2: begin
				e_we    = 1'b1;
				e_waddr = {b_q, a_q};
				e_wdata = w_q;
			end
			default: begin
				e_we = 1'b0;
			end
		endcase
	end
	assign e_raddr = {u_q, v_q};

	// Node memory: seed the source, write back relaxed neighbors
	always_comb begin
		n_we    = 1'b0;
		n_waddr = v_s1;
		n_wdata = {nd, u_q};
		if (state_q == S_INIT) begin
			n_we    = 1'b1;
			n_waddr = src_q;
			n_wdata = {{dgsp_pkg::DIST_BITS{1'b0}}, src_q};
		end else if (upd) begin
			n_we = 1'b1;
		end
	end
	assign n_raddr = (state_q == S_WALK_RD) ? node_q : v_q;

	dgsp_ram #(.WIDTH(dgsp_pkg::WEIGHT_BITS), .DEPTH(dgsp_pkg::EDGE_DEPTH)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	dgsp_ram #(.WIDTH(dgsp_pkg::ENTRY_BITS), .DEPTH(dgsp_pkg::NODE_COUNT)) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	// Relaxation step on the data read in the previous cycle
	assign rctl.valid   = valid_s1;
	assign rctl.clear   = (state_q == S_INIT) || (state_q == S_DECIDE);
	assign rctl.visited = visited_q[v_s1];
	assign rctl.reached = reached_q[v_s1];

	dgsp_relax u_relax (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rctl),
		.v      (v_s1),
		.du     (du_q),
		.w      (e_rdata),
		.d      (n_rdist),
		.upd    (upd),
		.nd     (nd),
		.best   (best)
	);

	assign fin = (node_q == src_q) || (k_q == dgsp_pkg::NODE_BITS'(dgsp_pkg::MAX_ITEMS - 1));

	// Sequence clear, edge writes, search passes and the path walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			visited_q <= '0;
			reached_q <= '0;
			valid_s1  <= 1'b0;
			strobe_q  <= 1'b0;
			picks_q   <= '0;
			k_q       <= '0;
			v_q       <= '0;
		end else begin
			valid_s1 <= (state_q == S_RELAX);
			v_s1     <= v_q;
			strobe_q <= 1'b0;
			if (upd) begin
				reached_q[v_s1] <= 1'b1;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == dgsp_pkg::EDGE_ADDR_BITS'(dgsp_pkg::EDGE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						a_q    <= first_node;
						b_q    <= second_node;
						w_q    <= weight;
						src_q  <= first_node;
						goal_q <= second_node;
						state_q <= (command == dgsp_pkg::CMD_SET) ? S_EDGE2 : S_INIT;
					end
				end
				S_EDGE2: begin
					state_q <= S_IDLE;
				end
				S_INIT: begin
					// only the source is visited and reached
					visited_q <= dgsp_pkg::NODE_COUNT'(1) << src_q;
					reached_q <= dgsp_pkg::NODE_COUNT'(1) << src_q;
					u_q     <= src_q;
					du_q    <= '0;
					picks_q <= dgsp_pkg::NODE_BITS'(1);
					v_q     <= '0;
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					v_q <= v_q + 1'b1;
					if (v_q == dgsp_pkg::NODE_BITS'(dgsp_pkg::NODE_COUNT - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (best.found &&
					    (picks_q != dgsp_pkg::NODE_BITS'(dgsp_pkg::NODE_COUNT - 1))) begin
						u_q  <= best.node;
						du_q <= best.cost;
						visited_q[best.node] <= 1'b1;
						picks_q <= picks_q + 1'b1;
						v_q     <= '0;
						state_q <= S_RELAX;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					node_q <= goal_q;
					k_q    <= '0;
					if (!reached_q[goal_q]) begin
						strobe_q <= 1'b1;
						pnode_q  <= goal_q;
						pdist_q  <= '0;
						unr_q    <= 1'b1;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_EM;
				end
				S_WALK_EM: begin
					strobe_q <= 1'b1;
					pnode_q  <= node_q;
					pdist_q  <= n_rdist;
					unr_q    <= 1'b0;
					last_q   <= fin;
					node_q   <= n_rpar;
					k_q      <= k_q + 1'b1;
					state_q  <= fin ? S_IDLE : S_WALK_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign result_strobe = strobe_q;
	assign path_node     = pnode_q;
	assign path_distance = pdist_q;
	assign unreachable   = unr_q;
	assign last          = last_q;

	`DGSP_ASSERT_NOW(a_unr_last, clk, arst_n, result_strobe && unreachable, last)
	`DGSP_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`DGSP_ASSERT_NEXT(a_item_gap, clk, arst_n, result_strobe && !last, !result_strobe)
	`DGSP_ASSERT_NOW(a_relax_src, clk, arst_n, state_q == S_RELAX, reached_q[src_q] && visited_q[u_q])

endmodule

@@ test/shortest_path_checker.sv @@
`timescale 1ns / 1ps

module shortest_path_checker
	import dgsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  logic    command,
	input  node_t   first_node,
	input  node_t   second_node,
	input  weight_t weight,
	input  logic    result_strobe,
	input  node_t   path_node,
	input  dist_t   path_distance,
	input  logic    unreachable,
	input  logic    last,
	output int      mismatches,
	output int      pending
);

	localparam int unsigned DIST_CEIL = (1 << DIST_BITS) - 1;

	typedef struct packed {
		node_t node;
		dist_t cost;
		logic  unr;
		logic  fin;
	} path_hop_t;

	// Mirror of the symmetric weight memory
	weight_t   edge_cost [NODE_COUNT][NODE_COUNT];
	path_hop_t hop_queue [$];
	int        error_count = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	function automatic dist_t clip_dist(int unsigned d);
		return (d > DIST_CEIL) ? dist_t'(DIST_CEIL) : dist_t'(d);
	endfunction

	// Run the search from src and queue the goal's path, goal first
	function automatic void compute_path(node_t src, node_t goal);
		int unsigned cost_to [NODE_COUNT];
		int          parent [NODE_COUNT];
		bit          visited [NODE_COUNT];
		bit          reached [NODE_COUNT];
		int          best;
		int unsigned best_dist;
		int unsigned cand;
		int          node;
		int          k;
		bit          fin;
		path_hop_t   hop;
		for (int i = 0; i < NODE_COUNT; i++) begin
			cost_to[i] = 0;
			parent[i] = 0;
			visited[i] = 1'b0;
			reached[i] = 1'b0;
		end
		reached[src] = 1'b1;
		for (int i = 0; i < NODE_COUNT - 1; i++) begin
			// take the lowest-index unvisited reached node of smallest distance
			best = -1;
			best_dist = 0;
			for (int v = 0; v < NODE_COUNT; v++) begin
				if (!visited[v] && reached[v] && (best < 0 || cost_to[v] < best_dist)) begin
					best = v;
					best_dist = cost_to[v];
				end
			end
			if (best < 0)
				break;
			visited[best] = 1'b1;
			// relax neighbors on a first reach or a strictly shorter distance
			for (int v = 0; v < NODE_COUNT; v++) begin
				if (visited[v] || edge_cost[best][v] == '0)
					continue;
				cand = cost_to[best] + edge_cost[best][v];
				if (!reached[v] || cand < cost_to[v]) begin
					cost_to[v] = cand;
					parent[v] = best;
					reached[v] = 1'b1;
				end
			end
		end
		if (!reached[goal]) begin
			hop = '{node: goal, cost: '0, unr: 1'b1, fin: 1'b1};
			hop_queue.push_back(hop);
			return;
		end
		node = goal;
		k = 0;
		while (k < MAX_ITEMS) begin
			fin = (node == src) || (k == MAX_ITEMS - 1);
			hop = '{node: node_t'(node), cost: clip_dist(cost_to[node]), unr: 1'b0, fin: fin};
			hop_queue.push_back(hop);
			k++;
			if (fin)
				break;
			node = parent[node] % NODE_COUNT;
		end
	endfunction

	always @(posedge clk) begin
		path_hop_t exp_hop;
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++)
				for (int j = 0; j < NODE_COUNT; j++)
					edge_cost[i][j] = '0;
			hop_queue.delete();
		end else begin
			// compare each result item with the oldest expected hop
			if (result_strobe) begin
				if (hop_queue.size() == 0) begin
					if (error_count < 10)
						$display("%0t: unexpected result node %0d dist %0d unr %0b last %0b",
							$realtime, path_node, path_distance, unreachable, last);
					error_count++;
				end else begin
					exp_hop = hop_queue.pop_front();
					if (path_node !== exp_hop.node || path_distance !== exp_hop.cost ||
							unreachable !== exp_hop.unr || last !== exp_hop.fin) begin
						if (error_count < 10)
							$display({"%0t: mismatch expected node %0d dist %0d unr %0b ",
								"last %0b, got node %0d dist %0d unr %0b last %0b"},
								$realtime, exp_hop.node, exp_hop.cost, exp_hop.unr,
								exp_hop.fin, path_node, path_distance, unreachable,
								last);
						error_count++;
					end
				end
			end
			// apply an accepted item to the mirror or predict its path
			if (start && !busy) begin
				if (command == CMD_SET) begin
					edge_cost[first_node][second_node] = weight;
					edge_cost[second_node][first_node] = weight;
				end else begin
					compute_path(first_node, second_node);
				end
			end
		end
		mismatches <= error_count;
		pending <= hop_queue.size();
	end

endmodule

@@ test/tb_dense_graph_shortest_path.sv @@
`timescale 1ns / 1ps

module tb_dense_graph_shortest_path;
	import dgsp_pkg::*;

	localparam int ITEM_TARGET    = 270;
	localparam int QUIET_AFTER    = 230;
	// slowest quiet stretch: weight clear after reset, then a full search
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES   = 1200;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    command;
	node_t   first_node;
	node_t   second_node;
	weight_t weight;
	logic    result_strobe;
	node_t   path_node;
	dist_t   path_distance;
	logic    unreachable;
	logic    last;

	int mismatches;
	int pending;
	int sent = 0;
	int stall_count = 0;
	bit idle_mode = 1'b1;

	dense_graph_shortest_path uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.first_node    (first_node),
		.second_node   (second_node),
		.weight        (weight),
		.result_strobe (result_strobe),
		.path_node     (path_node),
		.path_distance (path_distance),
		.unreachable   (unreachable),
		.last          (last)
	);

	shortest_path_checker u_path_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.first_node    (first_node),
		.second_node   (second_node),
		.weight        (weight),
		.result_strobe (result_strobe),
		.path_node     (path_node),
		.path_distance (path_distance),
		.unreachable   (unreachable),
		.last          (last),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe) begin
			stall_count <= 0;
		end else if (stall_count >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// Hold the item until the block takes it
	task automatic send_item(logic cmd, node_t a, node_t b, weight_t w);
		start <= 1'b1;
		command <= cmd;
		first_node <= a;
		second_node <= b;
		weight <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
	endtask

	// Drop start for a random burst, except in quiet stretches and near the end
	task automatic maybe_pause();
		if (idle_mode && sent < QUIET_AFTER && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(posedge clk);
		end
	endtask

	task automatic set_edge(int a, int b, int w);
		maybe_pause();
		send_item(CMD_SET, node_t'(a), node_t'(b), weight_t'(w));
	endtask

	task automatic ask_path(int src, int goal);
		maybe_pause();
		send_item(CMD_QUERY, node_t'(src), node_t'(goal), weight_t'($urandom));
	endtask

	// Favor extremes and small costs so that multi-hop paths win
	function automatic int pick_weight();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 16'hFFFF;
			3, 4: return $urandom_range(1, 15);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	// Lay a path over shuffled nodes, then ask for one end from the other
	task automatic run_chain();
		int perm [NODE_COUNT];
		int len;
		int j;
		int tmp;
		for (int i = 0; i < NODE_COUNT; i++)
			perm[i] = i;
		for (int i = NODE_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		len = ($urandom_range(0, 3) == 0) ? NODE_COUNT - 1 : $urandom_range(2, 8);
		for (int i = 0; i < len; i++)
			set_edge(perm[i], perm[i + 1],
				($urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom_range(1, 16'hFFFF));
		if ($urandom_range(0, 1))
			ask_path(perm[0], perm[len]);
		else
			ask_path(perm[len], perm[0]);
	endtask

	initial begin
		int base;
		int n;
		arst_n <= 1'b0;
		start <= 1'b0;
		command <= CMD_SET;
		first_node <= '0;
		second_node <= '0;
		weight <= '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;

		// empty graph, then source equal to goal
		ask_path(0, 31);
		ask_path(5, 5);
		// two-hop path with the largest weight, both directions
		set_edge(0, 1, 16'hFFFF);
		set_edge(1, 2, 1);
		ask_path(0, 2);
		ask_path(2, 0);
		// self loop never shortens anything
		set_edge(3, 3, 7);
		ask_path(3, 3);
		ask_path(3, 0);
		// equal-cost routes: lower index settles first, ties do not relax
		set_edge(0, 4, 5);
		set_edge(0, 5, 5);
		set_edge(4, 6, 1);
		set_edge(5, 6, 1);
		ask_path(0, 6);
		// removed edge cuts the goal off
		set_edge(1, 2, 0);
		ask_path(0, 2);
		// top nodes joined in
		set_edge(31, 30, 1);
		set_edge(30, 0, 2);
		ask_path(31, 6);
		ask_path(31, 1);
		set_edge(31, 31, 0);
		ask_path(6, 31);

		// random episodes, mostly edge updates followed by a query
		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 5) == 0)
				idle_mode = !idle_mode;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					base = $urandom_range(0, NODE_COUNT - 1);
					n = $urandom_range(1, 4);
					repeat (n)
						set_edge(base + $urandom_range(0, 7), base + $urandom_range(0, 7),
							pick_weight());
					if ($urandom_range(0, 3) == 0)
						ask_path(base + $urandom_range(0, 7), $urandom_range(0, 31));
					else
						ask_path(base + $urandom_range(0, 7), base + $urandom_range(0, 7));
				end
				6, 7: run_chain();
				8: begin
					if ($urandom_range(0, 1))
						set_edge($urandom_range(0, 31), $urandom_range(0, 31),
							$urandom_range(0, 16'hFFFF));
					else
						ask_path($urandom_range(0, 31), $urandom_range(0, 31));
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n)
						set_edge($urandom_range(0, 31), $urandom_range(0, 31), 0);
					ask_path($urandom_range(0, 31), $urandom_range(0, 31));
				end
			endcase
		end
		start <= 1'b0;

		// drain the expected hops, then watch for stray results
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+src
src/dgsp_pkg.sv
src/dgsp_ram.sv
src/dgsp_relax.sv
src/dense_graph_shortest_path.sv
test/shortest_path_checker.sv
test/tb_dense_graph_shortest_path.sv
